// ===== rtl/deq_pkg.sv =====
// Shared types and constants of the double-ended queue.
`default_nettype none

package deq_pkg;

    localparam int DEPTH  = 64;
    localparam int WIDTH  = 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int KIND_W = 3;
    localparam int POS_W  = 6;
    localparam int STAT_W = 2;

    typedef logic [WIDTH-1:0]  word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_READ       = 3'd4
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_UP   = 2'd1,
        CELL_SHIFT_DOWN = 2'd2,
        CELL_LOAD       = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        idx_t     wr_idx;
        idx_t     rd_idx;
        word_t    word;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/deq_if.sv =====
// Request and response channel interfaces of the double-ended queue.
`default_nettype none

interface deq_req_if;
    logic                          valid;
    logic                          ready;
    logic [deq_pkg::KIND_W-1:0]    kind;
    deq_pkg::word_t                value;
    deq_pkg::pos_t                 position;

    modport source (output valid, kind, value, position, input ready);
    modport sink   (input valid, kind, value, position, output ready);
endinterface

interface deq_rsp_if;
    logic                          valid;
    logic                          ready;
    deq_pkg::word_t                data;
    logic [deq_pkg::STAT_W-1:0]    status;
    deq_pkg::fill_t                fill;

    modport source (output valid, data, status, fill, input ready);
    modport sink   (input valid, data, status, fill, output ready);
endinterface

`default_nettype wire

// ===== rtl/deq_cell.sv =====
// One storage cell of the queue chain: holds a word, shifts, loads, offers it for reading.
`default_nettype none

module deq_cell (
    input  wire logic               clk,
    input  wire deq_pkg::cell_ctl_t ctl,
    input  wire deq_pkg::idx_t      idx,
    input  wire deq_pkg::word_t     left,
    input  wire deq_pkg::word_t     right,
    output deq_pkg::word_t          word,
    output deq_pkg::word_t          rd_word
);

    deq_pkg::word_t word_reg;
    deq_pkg::word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        case (ctl.op)
            deq_pkg::CELL_HOLD:       word_next = word_reg;
            deq_pkg::CELL_SHIFT_UP:   word_next = left;
            deq_pkg::CELL_SHIFT_DOWN: word_next = right;
            deq_pkg::CELL_LOAD:
            begin
                if (ctl.wr_idx == idx)
                begin
                    word_next = ctl.word;
                end
            end
            default:                  word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (ctl.rd_idx == idx) ? word_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: request decode, fill count, cell chain, response register.
//
//   channel | dir | payload                      | handshake
//   req     | in  | kind, value, position         | valid/ready
//   rsp     | out | data, status, fill            | valid/ready
//
// One request per cycle while the response register can take it; the response appears in the cycle after acceptance.
// A new request is taken while the response register is empty or being drained.
// Words sit in a chain of DEPTH cells with the front in cell 0; front pushes and
// pops shift the whole chain by one in the same cycle.
// Reset empties the queue and the response register; cell contents are left as is.
`default_nettype none

module double_ended_queue (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    logic                 accept;
    deq_pkg::fill_t       count_reg;
    deq_pkg::fill_t       count_next;
    deq_pkg::fill_t       count_dec;
    logic                 full;
    logic                 empty;
    logic                 hit;
    deq_pkg::status_t     status_next;
    deq_pkg::word_t       data_sel;
    deq_pkg::word_t       data_next;
    deq_pkg::cell_ctl_t   ctl;

    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    deq_pkg::word_t       data_reg;
    deq_pkg::status_t     status_reg;
    deq_pkg::fill_t       fill_reg;

    deq_pkg::word_t       cell_word [deq_pkg::DEPTH];
    deq_pkg::word_t       cell_rd   [deq_pkg::DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == deq_pkg::fill_t'(deq_pkg::DEPTH));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - deq_pkg::fill_t'(1);

    always_comb
    begin
        ctl.op      = deq_pkg::CELL_HOLD;
        ctl.wr_idx  = count_reg[deq_pkg::IDX_W-1:0];
        ctl.rd_idx  = '0;
        ctl.word    = req.value;
        hit         = 1'b0;
        status_next = deq_pkg::ST_OK;
        count_next  = count_reg;
        if (accept)
        begin
            case (deq_pkg::kind_t'(req.kind))
                deq_pkg::KIND_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.op     = deq_pkg::CELL_SHIFT_UP;
                        count_next = count_reg + deq_pkg::fill_t'(1);
                    end
                end
                deq_pkg::KIND_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.op     = deq_pkg::CELL_LOAD;
                        count_next = count_reg + deq_pkg::fill_t'(1);
                    end
                end
                deq_pkg::KIND_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.op     = deq_pkg::CELL_SHIFT_DOWN;
                        hit        = 1'b1;
                        count_next = count_dec;
                    end
                end
                deq_pkg::KIND_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.rd_idx = count_dec[deq_pkg::IDX_W-1:0];
                        hit        = 1'b1;
                        count_next = count_dec;
                    end
                end
                deq_pkg::KIND_READ:
                begin
                    if (deq_pkg::fill_t'(req.position) >= count_reg)
                    begin
                        status_next = deq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        ctl.rd_idx = deq_pkg::idx_t'(req.position);
                        hit        = 1'b1;
                    end
                end
                default:
                begin
                    status_next = deq_pkg::ST_OK;
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < deq_pkg::DEPTH; gi++)
        begin : g_cell
            deq_pkg::word_t left_word;
            deq_pkg::word_t right_word;

            if (gi == 0)
            begin : g_first
                assign left_word = req.value;
            end
            else
            begin : g_mid_left
                assign left_word = cell_word[gi-1];
            end

            if (gi == deq_pkg::DEPTH - 1)
            begin : g_last
                assign right_word = '0;
            end
            else
            begin : g_mid_right
                assign right_word = cell_word[gi+1];
            end

            deq_cell u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .idx     (deq_pkg::idx_t'(gi)),
                .left    (left_word),
                .right   (right_word),
                .word    (cell_word[gi]),
                .rd_word (cell_rd[gi])
            );
        end
    endgenerate

    always_comb
    begin
        data_sel = '0;
        for (int i = 0; i < deq_pkg::DEPTH; i++)
        begin
            data_sel = data_sel | cell_rd[i];
        end
        data_next = hit ? data_sel : '0;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
            fill_reg   <= count_next;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.data   = data_reg;
    assign rsp.status = status_reg;
    assign rsp.fill   = fill_reg;

endmodule

`default_nettype wire

// ===== rtl/deq_checker.sv =====
// Port-level assertions of the double-ended queue and their binding to the top level.
`default_nettype none

module deq_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_ready,
    input wire deq_pkg::word_t             data,
    input wire logic [deq_pkg::STAT_W-1:0] status,
    input wire deq_pkg::fill_t             fill
);

    // hold a stalled transaction
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(data) && $stable(status)
            && $stable(fill))
        else $error("response changed while stalled");

    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == deq_pkg::ST_FULL |-> fill == deq_pkg::fill_t'(deq_pkg::DEPTH))
        else $error("refused push with queue not full");

    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == deq_pkg::ST_EMPTY |-> fill == '0)
        else $error("refused pop with queue not empty");

    a_err_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != deq_pkg::ST_OK |-> data == '0)
        else $error("nonzero data on refused request");

    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> fill <= deq_pkg::fill_t'(deq_pkg::DEPTH))
        else $error("fill beyond depth");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .data      (rsp.data),
    .status    (rsp.status),
    .fill      (rsp.fill)
);

`default_nettype wire

// ===== test/double_ended_queue_tb.sv =====
// Self-checking testbench of the double-ended queue: random and directed requests against a ring model.
`default_nettype none

module double_ended_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [deq_pkg::KIND_W-1:0] kind_bits_t;

    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_WAIT  = 10;
    localparam int PHASE_ITEMS  = 300;

    localparam kind_bits_t KIND_SPARE_LO  = 3'd5;
    localparam kind_bits_t KIND_SPARE_MID = 3'd6;
    localparam kind_bits_t KIND_SPARE_HI  = 3'd7;

    typedef struct packed {
        kind_bits_t                 kind;
        deq_pkg::word_t             value;
        deq_pkg::pos_t              position;
    } request_t;

    typedef struct packed {
        deq_pkg::word_t             data;
        logic [deq_pkg::STAT_W-1:0] status;
        deq_pkg::fill_t             fill;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    request_t pending_requests[$];
    answer_t  awaited_answers[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;

    deq_pkg::word_t ring_words[deq_pkg::DEPTH];
    int             ring_head;
    int             ring_count;

    int requests_seen;
    int full_refusals;
    int empty_refusals;
    int range_refusals;
    int peak_fill;
    int gen_fill;

    function automatic answer_t apply_request(request_t rq);
        answer_t ans;
        int      slot;
        ans.data   = '0;
        ans.status = deq_pkg::ST_OK;
        case (rq.kind)
            deq_pkg::KIND_PUSH_FRONT:
                if (ring_count >= deq_pkg::DEPTH)
                begin
                    ans.status = deq_pkg::ST_FULL;
                end
                else
                begin
                    ring_head = (ring_head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                    ring_words[ring_head] = rq.value;
                    ring_count++;
                end
            deq_pkg::KIND_PUSH_BACK:
                if (ring_count >= deq_pkg::DEPTH)
                begin
                    ans.status = deq_pkg::ST_FULL;
                end
                else
                begin
                    slot = (ring_head + ring_count) % deq_pkg::DEPTH;
                    ring_words[slot] = rq.value;
                    ring_count++;
                end
            deq_pkg::KIND_POP_FRONT:
                if (ring_count == 0)
                begin
                    ans.status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    ans.data  = ring_words[ring_head];
                    ring_head = (ring_head + 1) % deq_pkg::DEPTH;
                    ring_count--;
                end
            deq_pkg::KIND_POP_BACK:
                if (ring_count == 0)
                begin
                    ans.status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    slot = (ring_head + ring_count - 1) % deq_pkg::DEPTH;
                    ans.data = ring_words[slot];
                    ring_count--;
                end
            deq_pkg::KIND_READ:
                if (int'(rq.position) >= ring_count)
                begin
                    ans.status = deq_pkg::ST_RANGE;
                end
                else
                begin
                    slot = (ring_head + int'(rq.position)) % deq_pkg::DEPTH;
                    ans.data = ring_words[slot];
                end
            default: ;
        endcase
        ans.fill = deq_pkg::fill_t'(ring_count);
        return ans;
    endfunction

    task automatic queue_request(kind_bits_t kind, deq_pkg::word_t value,
                                 deq_pkg::pos_t position);
        request_t rq;
        rq.kind     = kind;
        rq.value    = value;
        rq.position = position;
        pending_requests = {pending_requests, rq};
        case (kind)
            deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK:
                if (gen_fill < deq_pkg::DEPTH) gen_fill++;
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK:
                if (gen_fill > 0) gen_fill--;
            default: ;
        endcase
    endtask

    task automatic queue_random_phase(int target);
        int            made;
        int            burst;
        int            n;
        int            pick;
        deq_pkg::pos_t pos;
        made = 0;
        while (made < target)
        begin
            burst = $urandom_range(0, 9);
            if (burst < 3)
            begin
                n = $urandom_range(1, 70);
                repeat (n)
                begin
                    queue_request($urandom_range(0, 1) ? deq_pkg::KIND_PUSH_BACK
                                                       : deq_pkg::KIND_PUSH_FRONT,
                                  deq_pkg::word_t'($urandom_range(0, 255)),
                                  deq_pkg::pos_t'($urandom_range(0, 63)));
                end
                made += n;
            end
            else if (burst < 6)
            begin
                n = $urandom_range(1, 70);
                repeat (n)
                begin
                    queue_request($urandom_range(0, 1) ? deq_pkg::KIND_POP_BACK
                                                       : deq_pkg::KIND_POP_FRONT,
                                  deq_pkg::word_t'($urandom_range(0, 255)),
                                  deq_pkg::pos_t'($urandom_range(0, 63)));
                end
                made += n;
            end
            else if (burst < 9)
            begin
                n = $urandom_range(1, 20);
                repeat (n)
                begin
                    pick = $urandom_range(0, 4);
                    if ($urandom_range(0, 3) == 0)
                        pos = deq_pkg::pos_t'($urandom_range(0, 63));
                    else
                        pos = deq_pkg::pos_t'($urandom_range(0, (gen_fill > 63) ? 63 : gen_fill));
                    queue_request(kind_bits_t'(pick), deq_pkg::word_t'($urandom_range(0, 255)),
                                  pos);
                end
                made += n;
            end
            else
            begin
                queue_request(kind_bits_t'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                              deq_pkg::word_t'($urandom_range(0, 255)),
                              deq_pkg::pos_t'($urandom_range(0, 63)));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_requests.size() != 0 || req_ch.valid || awaited_answers.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        request_t rq;
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.kind     <= '0;
            req_ch.value    <= '0;
            req_ch.position <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                rq = pending_requests[0];
                pending_requests.delete(0);
                req_ch.valid    <= 1'b1;
                req_ch.kind     <= rq.kind;
                req_ch.value    <= rq.value;
                req_ch.position <= rq.position;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        answer_t  want;
        request_t rq;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $error("unexpected transaction: data %0h status %0d fill %0d",
                           rsp_ch.data, rsp_ch.status, rsp_ch.fill);
                    mismatches++;
                end
                else
                begin
                    want = awaited_answers[0];
                    awaited_answers.delete(0);
                    if (rsp_ch.data !== want.data)
                    begin
                        $error("data: expected %0h, got %0h", want.data, rsp_ch.data);
                        mismatches++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.fill !== want.fill)
                    begin
                        $error("fill: expected %0d, got %0d", want.fill, rsp_ch.fill);
                        mismatches++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                rq.kind     = req_ch.kind;
                rq.value    = req_ch.value;
                rq.position = req_ch.position;
                want = apply_request(rq);
                awaited_answers = {awaited_answers, want};
                requests_seen++;
                case (want.status)
                    deq_pkg::ST_FULL:  full_refusals++;
                    deq_pkg::ST_EMPTY: empty_refusals++;
                    deq_pkg::ST_RANGE: range_refusals++;
                    default: ;
                endcase
                if (int'(want.fill) > peak_fill) peak_fill = int'(want.fill);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("** double_ended_queue: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        req_ch.valid    = 1'b0;
        req_ch.kind     = '0;
        req_ch.value    = '0;
        req_ch.position = '0;
        rsp_ch.ready    = 1'b0;
        ring_head       = 0;
        ring_count      = 0;
        requests_seen   = 0;
        full_refusals   = 0;
        empty_refusals  = 0;
        range_refusals  = 0;
        peak_fill       = 0;
        gen_fill        = 0;
        rst_n           = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 17;
        snk_idle_pct = 57;
        queue_request(deq_pkg::KIND_POP_FRONT, 8'h00, 6'd0);
        queue_request(deq_pkg::KIND_POP_BACK, 8'hFF, 6'd63);
        queue_request(deq_pkg::KIND_READ, 8'h00, 6'd0);
        queue_request(deq_pkg::KIND_READ, 8'hFF, 6'd63);
        queue_request(deq_pkg::KIND_PUSH_BACK, 8'h00, 6'd63);
        queue_request(deq_pkg::KIND_PUSH_FRONT, 8'hFF, 6'd0);
        queue_request(deq_pkg::KIND_READ, 8'h00, 6'd0);
        queue_request(deq_pkg::KIND_READ, 8'h00, 6'd1);
        queue_request(deq_pkg::KIND_READ, 8'h00, 6'd2);
        queue_request(KIND_SPARE_LO, 8'hFF, 6'd63);
        queue_request(KIND_SPARE_MID, 8'h5A, 6'd21);
        queue_request(KIND_SPARE_HI, 8'hA5, 6'd42);
        queue_request(deq_pkg::KIND_PUSH_BACK, 8'hA5, 6'd0);
        queue_request(deq_pkg::KIND_PUSH_FRONT, 8'h5A, 6'd0);
        queue_request(deq_pkg::KIND_READ, 8'h00, 6'd3);
        queue_request(deq_pkg::KIND_POP_BACK, 8'h00, 6'd0);
        queue_request(deq_pkg::KIND_POP_FRONT, 8'h00, 6'd0);
        queue_request(deq_pkg::KIND_POP_FRONT, 8'h00, 6'd0);
        queue_request(deq_pkg::KIND_POP_BACK, 8'h00, 6'd0);
        queue_request(deq_pkg::KIND_POP_BACK, 8'h00, 6'd0);
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        src_idle_pct = 57;
        snk_idle_pct = 17;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        repeat (SETTLE_WAIT) @(posedge clk);
        $display("Ran %0d requests under three idle patterns; peak fill %0d of %0d.",
                 requests_seen, peak_fill, deq_pkg::DEPTH);
        $display("Refused pushes on full %0d, pops on empty %0d, out-of-range reads %0d.",
                 full_refusals, empty_refusals, range_refusals);
        if (mismatches == 0 && awaited_answers.size() == 0)
            $display("** double_ended_queue: PASSED **");
        else
            $display("** double_ended_queue: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
